// ----- rtl/assert_macros.svh -----
// Assertion helper macros for the line rasteriser RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define CLR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, inactive during reset.
`define CLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/clr_pkg.sv -----
// Shared types, constants and helpers for the clipped line rasteriser.
// No dependencies; used by every module of the block.
package clr_pkg;

  localparam int MAX_FRAME_DIM = 4096;
  localparam int DIM_W         = 13;
  localparam int COORD_W       = 16;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int PROD_W        = 2 * DIFF_W;
  localparam int DIVD_W        = 32;
  localparam int DIVS_W        = 16;
  localparam int DCNT_W        = 6;
  localparam int ROUND_W       = 5;
  localparam int CLIP_ROUNDS   = 16;
  localparam int ADDR_W        = 24;
  localparam int COLOUR_W      = 32;
  localparam int ACC_W         = 15;
  localparam int INC_W         = 14;
  localparam int IN_DATA_W     = 96;
  localparam int OUT_DATA_W    = 88;

  localparam logic [3:0] OC_LEFT  = 4'd1;
  localparam logic [3:0] OC_RIGHT = 4'd2;
  localparam logic [3:0] OC_ABOVE = 4'd4;
  localparam logic [3:0] OC_BELOW = 4'd8;

  typedef enum logic {OP_LOAD = 1'b0, OP_STEP = 1'b1} op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_PIXEL    = 2'd2,
    ST_NO_LINE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {REG_WIDTH = 2'd0, REG_HEIGHT = 2'd1} reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CLIP, S_MUL, S_DIVS, S_DIVW, S_UPD, S_EMIT_ACC, S_EMIT_REJ
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic prep;
    logic mul;
    logic div_start;
    logic update;
    logic accept;
    logic reject;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic both_out;
    logic both_in;
    logic rounds_out;
    logic den_zero;
    logic div_done;
  } stat_t;

  function automatic logic [3:0] outcode(input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y,
                                         input logic [DIM_W-1:0] w,
                                         input logic [DIM_W-1:0] h);
    logic [3:0] c;
    c = 4'd0;
    if (x < 0) c = c | OC_LEFT;
    else if ({x[COORD_W-1], x} > $signed({{(DIFF_W-DIM_W){1'b0}}, w})) c = c | OC_RIGHT;
    if (y < 0) c = c | OC_ABOVE;
    else if ({y[COORD_W-1], y} > $signed({{(DIFF_W-DIM_W){1'b0}}, h})) c = c | OC_BELOW;
    return c;
  endfunction

endpackage

// ----- rtl/clipped_line_rasterizer.sv -----
// Clipped line rasteriser: outcode clipping of a line to the frame, then pixel stepping.
// Top level; depends on clr_pkg, clr_ctrl and clr_datapath.
//
// Channels: in_* carries requests; in_tuser 0 loads a line (endpoints and colour in
// in_tdata), 1 asks for the next pixel. out_* returns one result per request, status in
// out_tuser, last pixel in out_tlast. cfg_* writes frame width (index 0) and height (1).
// The block accepts one pixel request per cycle while the result register drains, so
// pixels stream at one per cycle, each result held in the registered output.
// A load runs the clip check, then per clipping round (at most four in practice, sixteen
// allowed) prepare, multiply, a division in the shared bit-serial divider and update;
// a round whose divisor is zero skips the division. No request is taken during a load.
// Reset: frame 640 x 480, no active line; no clearing pass.
// When the receiver stalls, the result holds in the output register and in_tready
// drops until it is taken.
module clipped_line_rasterizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48], line_colour_in[95:64]
  input  logic [clr_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_x[12:0], pixel_y[25:13], pixel_address[49:26], pixel_colour[81:50],
  // write_enable[82], zero[87:83]
  output logic [clr_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]                     out_tuser,
  output logic                           out_tlast,
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_index,
  input  logic [clr_pkg::DIM_W-1:0]      cfg_wdata
);

  clr_pkg::cmd_t  cmd;
  clr_pkg::stat_t stat;

  clr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  clr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/clr_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on clr_pkg for widths.
module clr_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [clr_pkg::DIVD_W-1:0] dividend,
  input  logic [clr_pkg::DIVS_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [clr_pkg::DIVD_W-1:0] quotient
);

  logic [clr_pkg::DIVS_W:0]   rem_r, rem_nxt;
  logic [clr_pkg::DIVD_W-1:0] quo_r, quo_nxt;
  logic [clr_pkg::DIVS_W-1:0] dvs_r;
  logic [clr_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt, done_r, done_nxt;
  logic [clr_pkg::DIVS_W+1:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[clr_pkg::DIVD_W-1]} - {2'b00, dvs_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = clr_pkg::DCNT_W'(clr_pkg::DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[clr_pkg::DIVS_W+1]) begin
        rem_nxt = trial[clr_pkg::DIVS_W:0];
        quo_nxt = {quo_r[clr_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[clr_pkg::DIVS_W-1:0], quo_r[clr_pkg::DIVD_W-1]};
        quo_nxt = {quo_r[clr_pkg::DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == clr_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) dvs_r <= divisor;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/clr_datapath.sv -----
// Datapath: frame registers, clipping arithmetic, Bresenham state and result register.
// Depends on clr_pkg, clr_divider and assert_macros.svh.
`include "assert_macros.svh"
module clr_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  clr_pkg::cmd_t                  cmd,
  output clr_pkg::stat_t                 stat,
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_index,
  input  logic [clr_pkg::DIM_W-1:0]      cfg_wdata,
  input  logic [clr_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [clr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                     out_tuser,
  output logic                           out_tlast
);
  localparam int CW = clr_pkg::COORD_W;
  localparam int DW = clr_pkg::DIM_W;
  localparam int FW = clr_pkg::DIFF_W;

  // frame size
  logic [DW-1:0] width_r, height_r, cfg_val;
  always_comb begin
    cfg_val = cfg_wdata;
    if (cfg_val == '0) cfg_val = DW'(1);
    else if (cfg_val > DW'(clr_pkg::MAX_FRAME_DIM)) cfg_val = DW'(clr_pkg::MAX_FRAME_DIM);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(640);
      height_r <= DW'(480);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        clr_pkg::REG_WIDTH:  width_r  <= cfg_val;
        clr_pkg::REG_HEIGHT: height_r <= cfg_val;
        default: ;
      endcase
    end
  end

  // clipping registers
  logic signed [CW-1:0] x0_r, y0_r, x1_r, y1_r, a0_r, bound_r;
  logic signed [FW-1:0] diffa_r, diffb_r, den_r;
  logic signed [clr_pkg::PROD_W-1:0] prod_r;
  logic [clr_pkg::ROUND_W-1:0] round_r;
  logic [clr_pkg::COLOUR_W-1:0] pend_colour_r;
  logic move1_r, horiz_r, neg_r;
  logic [3:0] c0, c1, csel;
  logic move1, horiz;
  logic signed [CW-1:0] a0, a1, b0, b1, bnd;

  assign c0 = clr_pkg::outcode(x0_r, y0_r, width_r, height_r);
  assign c1 = clr_pkg::outcode(x1_r, y1_r, width_r, height_r);
  assign move1 = c1 > c0;
  assign csel  = move1 ? c1 : c0;
  assign horiz = |(csel & (clr_pkg::OC_BELOW | clr_pkg::OC_ABOVE));

  always_comb begin
    if (horiz) begin
      a0 = x0_r; a1 = x1_r; b0 = y0_r; b1 = y1_r;
      bnd = |(csel & clr_pkg::OC_BELOW) ? $signed({{(CW-DW){1'b0}}, height_r}) : '0;
    end else begin
      a0 = y0_r; a1 = y1_r; b0 = x0_r; b1 = x1_r;
      bnd = |(csel & clr_pkg::OC_RIGHT) ? $signed({{(CW-DW){1'b0}}, width_r}) : '0;
    end
  end

  // divider
  logic [clr_pkg::PROD_W-1:0] prod_mag;
  logic [FW-1:0] den_mag;
  logic div_busy, div_done;
  logic [clr_pkg::DIVD_W-1:0] quo;
  assign prod_mag = prod_r[clr_pkg::PROD_W-1] ? -prod_r : prod_r;
  assign den_mag  = den_r[FW-1] ? -den_r : den_r;

  clr_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_mag[clr_pkg::DIVD_W-1:0]),
    .divisor  (den_mag[clr_pkg::DIVS_W-1:0]),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  logic signed [CW+1:0] q_s, new_a;
  always_comb begin
    q_s = (den_r == '0) ? '0 : $signed({2'b00, quo[CW-1:0]});
    if (neg_r) q_s = -q_s;
    new_a = {{2{a0_r[CW-1]}}, a0_r} + q_s;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r <= in_tdata[15:0];
      y0_r <= in_tdata[31:16];
      x1_r <= in_tdata[47:32];
      y1_r <= in_tdata[63:48];
      pend_colour_r <= in_tdata[95:64];
      round_r <= '0;
    end else if (cmd.update) begin
      round_r <= round_r + 1'b1;
      if (move1_r) begin
        x1_r <= horiz_r ? new_a[CW-1:0] : bound_r;
        y1_r <= horiz_r ? bound_r : new_a[CW-1:0];
      end else begin
        x0_r <= horiz_r ? new_a[CW-1:0] : bound_r;
        y0_r <= horiz_r ? bound_r : new_a[CW-1:0];
      end
    end
    if (cmd.prep) begin
      move1_r <= move1;
      horiz_r <= horiz;
      a0_r    <= a0;
      bound_r <= bnd;
      diffa_r <= FW'(a1) - FW'(a0);
      diffb_r <= FW'(bnd) - FW'(b0);
      den_r   <= FW'(b1) - FW'(b0);
    end
    if (cmd.mul) prod_r <= diffa_r * diffb_r;
    if (cmd.div_start) neg_r <= prod_r[clr_pkg::PROD_W-1] ^ den_r[FW-1];
  end

  // Bresenham state
  logic line_active_r, dir_r, swap_r;
  logic [DW-1:0] major_pos_r, minor_pos_r, major_end_r, span_r;
  logic signed [clr_pkg::ACC_W-1:0] acc_r;
  logic [clr_pkg::INC_W-1:0] inc_r;
  logic [clr_pkg::COLOUR_W-1:0] colour_r;

  // setup from clipped endpoints, all inside the frame now
  logic [DW-1:0] ax, ay, bx, by, sax, say, sbx, sby, ma, mi, me, mie;
  logic [DW-1:0] dx, dy;
  logic steep;
  always_comb begin
    ax = x0_r[DW-1:0]; ay = y0_r[DW-1:0]; bx = x1_r[DW-1:0]; by = y1_r[DW-1:0];
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    steep = dx < dy;
    sax = steep ? ay : ax; say = steep ? ax : ay;
    sbx = steep ? by : bx; sby = steep ? bx : by;
    if (sax > sbx) begin
      ma = sbx; mi = sby; me = sax; mie = say;
    end else begin
      ma = sax; mi = say; me = sbx; mie = sby;
    end
  end

  // pixel step
  logic [DW-1:0] px, py;
  logic last;
  logic [2*DW-1:0] addr_full;
  logic signed [clr_pkg::ACC_W:0] acc_sum, acc_new;
  logic minor_move;
  always_comb begin
    px = swap_r ? minor_pos_r : major_pos_r;
    py = swap_r ? major_pos_r : minor_pos_r;
    last = major_pos_r >= major_end_r;
    addr_full = py * width_r + (2*DW)'(px);
    acc_sum = {acc_r[clr_pkg::ACC_W-1], acc_r} + $signed({2'b00, inc_r});
    minor_move = acc_sum > $signed({{(clr_pkg::ACC_W+1-DW){1'b0}}, span_r});
    acc_new = minor_move ? acc_sum - $signed({{(clr_pkg::ACC_W-DW){1'b0}}, span_r, 1'b0})
                         : acc_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      major_pos_r <= '0; minor_pos_r <= '0; major_end_r <= '0; span_r <= '0;
      acc_r <= '0; inc_r <= '0; dir_r <= 1'b0; swap_r <= 1'b0; colour_r <= '0;
    end else if (cmd.accept) begin
      line_active_r <= 1'b1;
      swap_r <= steep;
      major_pos_r <= ma;
      minor_pos_r <= mi;
      major_end_r <= me;
      span_r <= me - ma;
      inc_r <= {((mie > mi) ? mie - mi : mi - mie), 1'b0};
      dir_r <= mie > mi;
      acc_r <= '0;
      colour_r <= pend_colour_r;
    end else if (cmd.step && line_active_r) begin
      major_pos_r <= major_pos_r + 1'b1;
      acc_r <= acc_new[clr_pkg::ACC_W-1:0];
      if (minor_move) minor_pos_r <= dir_r ? minor_pos_r + 1'b1 : minor_pos_r - 1'b1;
      if (last) line_active_r <= 1'b0;
    end
  end

  // result register
  logic out_valid_r;
  logic [clr_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [1:0] out_user_r;
  logic out_last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.step || cmd.accept || cmd.reject) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.step || cmd.accept || cmd.reject) begin
      out_data_r <= '0;
      out_last_r <= 1'b0;
      if (cmd.accept) out_user_r <= clr_pkg::ST_ACCEPTED;
      else if (cmd.reject) out_user_r <= clr_pkg::ST_REJECTED;
      else if (!line_active_r) out_user_r <= clr_pkg::ST_NO_LINE;
      else begin
        out_user_r <= clr_pkg::ST_PIXEL;
        out_data_r <= {5'd0, (px < width_r) && (py < height_r), colour_r,
                       addr_full[clr_pkg::ADDR_W-1:0], py, px};
        out_last_r <= last;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.both_out   = |(c0 & c1);
  assign stat.both_in    = (c0 | c1) == 4'd0;
  assign stat.rounds_out = round_r >= clr_pkg::ROUND_W'(clr_pkg::CLIP_ROUNDS);
  assign stat.den_zero   = den_r == '0;
  assign stat.div_done   = div_done;

  `CLR_ASSERT_IMPL(a_div_idle, clk, rst_n, cmd.div_start, !div_busy)
  `CLR_ASSERT_NEXT(a_accept_active, clk, rst_n, cmd.accept, line_active_r)
  `CLR_ASSERT_IMPL(a_major_bound, clk, rst_n, line_active_r, major_pos_r <= major_end_r)

endmodule

// ----- rtl/clr_ctrl.sv -----
// Controller state machine: sequences load, clipping rounds, division and results.
// Depends on clr_pkg.
module clr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           in_op,
  input  clr_pkg::stat_t stat,
  output clr_pkg::cmd_t  cmd
);

  clr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= clr_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      clr_pkg::S_IDLE: begin
        in_tready = stat.out_free;
        if (in_tvalid && stat.out_free) begin
          if (in_op == clr_pkg::OP_STEP) cmd.step = 1'b1;
          else begin
            cmd.load  = 1'b1;
            state_nxt = clr_pkg::S_CLIP;
          end
        end
      end
      clr_pkg::S_CLIP: begin
        if (stat.both_out) state_nxt = clr_pkg::S_EMIT_REJ;
        else if (stat.both_in) state_nxt = clr_pkg::S_EMIT_ACC;
        else if (stat.rounds_out) state_nxt = clr_pkg::S_EMIT_REJ;
        else begin
          cmd.prep  = 1'b1;
          state_nxt = clr_pkg::S_MUL;
        end
      end
      clr_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = clr_pkg::S_DIVS;
      end
      clr_pkg::S_DIVS: begin
        if (stat.den_zero) state_nxt = clr_pkg::S_UPD;
        else begin
          cmd.div_start = 1'b1;
          state_nxt     = clr_pkg::S_DIVW;
        end
      end
      clr_pkg::S_DIVW: begin
        if (stat.div_done) state_nxt = clr_pkg::S_UPD;
      end
      clr_pkg::S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = clr_pkg::S_CLIP;
      end
      clr_pkg::S_EMIT_ACC: begin
        if (stat.out_free) begin
          cmd.accept = 1'b1;
          state_nxt  = clr_pkg::S_IDLE;
        end
      end
      clr_pkg::S_EMIT_REJ: begin
        if (stat.out_free) begin
          cmd.reject = 1'b1;
          state_nxt  = clr_pkg::S_IDLE;
        end
      end
      default: state_nxt = clr_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for clipped_line_rasterizer: line loads and pixel steps
// against a behavioural clip/Bresenham predictor. Depends on clr_pkg and clipped_line_rasterizer.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_ITEMS = 1250;

  typedef struct {
    clr_pkg::status_t st;
    bit [12:0]    x;
    bit [12:0]    y;
    bit [23:0]    addr;
    bit [31:0]    col;
    bit           we;
    bit           last;
  } pixel_t;

  typedef struct {
    clr_pkg::op_t op;
    int           sx, sy, ex, ey;
    bit [31:0]    col;
    bit           typed;
    clr_pkg::status_t st;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [clr_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [clr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [clr_pkg::DIM_W-1:0] cfg_wdata = '0;

  clipped_line_rasterizer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned fw = 640, fh = 480;
  bit ln_active, min_up, swapped;
  int maj_pos, min_pos, maj_end, err_acc, err_inc, maj_span;
  bit [31:0] ln_colour;

  pixel_t expected_px[$];
  int errors = 0;
  int sent = 0;

  function automatic bit [3:0] region_code(longint x, longint y);
    bit [3:0] c;
    c = 4'd0;
    if (x < 0) c |= clr_pkg::OC_LEFT;
    else if (x > fw) c |= clr_pkg::OC_RIGHT;
    if (y < 0) c |= clr_pkg::OC_ABOVE;
    else if (y > fh) c |= clr_pkg::OC_BELOW;
    return c;
  endfunction

  function automatic longint cross_at(longint a0, longint a1, longint b0, longint b1,
                                      longint bound);
    if (b1 == b0) return a0;
    return a0 + (a1 - a0) * (bound - b0) / (b1 - b0);
  endfunction

  function automatic void move_point(longint x0, longint y0, longint x1, longint y1,
                                     bit [3:0] c, output longint rx, output longint ry);
    if (c & clr_pkg::OC_BELOW) begin
      rx = cross_at(x0, x1, y0, y1, fh); ry = fh;
    end else if (c & clr_pkg::OC_ABOVE) begin
      rx = cross_at(x0, x1, y0, y1, 0); ry = 0;
    end else if (c & clr_pkg::OC_RIGHT) begin
      ry = cross_at(y0, y1, x0, x1, fw); rx = fw;
    end else begin
      ry = cross_at(y0, y1, x0, x1, 0); rx = 0;
    end
  endfunction

  function automatic bit clip_and_setup(longint x0, longint y0, longint x1, longint y1);
    bit [3:0] c0, c1;
    int ax, ay, bx, by, t, dx, dy;
    c0 = region_code(x0, y0);
    c1 = region_code(x1, y1);
    for (int rnd = 0; ; rnd++) begin
      if ((c0 & c1) != 0) return 1'b0;
      if ((c0 | c1) == 0) break;
      if (rnd >= clr_pkg::CLIP_ROUNDS) return 1'b0;
      if (c1 > c0) begin
        move_point(x0, y0, x1, y1, c1, x1, y1);
        c1 = region_code(x1, y1);
      end else begin
        move_point(x0, y0, x1, y1, c0, x0, y0);
        c0 = region_code(x0, y0);
      end
    end
    ax = int'(x0); ay = int'(y0); bx = int'(x1); by = int'(y1);
    dx = ax > bx ? ax - bx : bx - ax;
    dy = ay > by ? ay - by : by - ay;
    swapped = dx < dy;
    if (swapped) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    maj_pos = ax; min_pos = ay; maj_end = bx; maj_span = bx - ax;
    err_inc = 2 * (by > ay ? by - ay : ay - by);
    err_acc = 0;
    min_up = by > ay;
    ln_active = 1'b1;
    return 1'b1;
  endfunction

  function automatic pixel_t rasterise(clr_pkg::op_t op, bit [clr_pkg::IN_DATA_W-1:0] d);
    pixel_t r;
    int px, py;
    r = '{st: clr_pkg::ST_NO_LINE, default: 0};
    if (op == clr_pkg::OP_LOAD) begin
      if (clip_and_setup($signed(d[15:0]), $signed(d[31:16]),
                         $signed(d[47:32]), $signed(d[63:48]))) begin
        ln_colour = d[95:64];
        r.st = clr_pkg::ST_ACCEPTED;
      end else
        r.st = clr_pkg::ST_REJECTED;
      return r;
    end
    if (!ln_active) return r;
    px = swapped ? min_pos : maj_pos;
    py = swapped ? maj_pos : min_pos;
    r.st = clr_pkg::ST_PIXEL;
    r.x = 13'(px); r.y = 13'(py);
    r.addr = 24'(longint'(py) * fw + px);
    r.col = ln_colour;
    r.we = (px < fw) && (py < fh);
    r.last = maj_pos >= maj_end;
    maj_pos++;
    err_acc += err_inc;
    if (err_acc > maj_span) begin
      min_pos += min_up ? 1 : -1;
      err_acc -= 2 * maj_span;
    end
    if (r.last) ln_active = 1'b0;
    return r;
  endfunction

  function automatic int rand_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  bit calm = 1'b0;  // stretch with no idling on either side

  task automatic send_request(clr_pkg::op_t op, bit [clr_pkg::IN_DATA_W-1:0] d,
                              bit typed = 0,
                              clr_pkg::status_t st = clr_pkg::ST_ACCEPTED);
    int gap;
    pixel_t r;
    gap = calm ? 0 : rand_gap();
    if (gap > 0) begin
      @(negedge clk) in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = d;
    do @(posedge clk); while (!in_tready);
    r = rasterise(op, d);
    if (typed) r.st = st;
    expected_px.push_back(r);
    sent++;
  endtask

  function automatic bit [clr_pkg::IN_DATA_W-1:0] pack_load(int sx, int sy, int ex, int ey,
                                                            bit [31:0] col);
    return {col, 16'(ey), 16'(ex), 16'(sy), 16'(sx)};
  endfunction

  task automatic wait_idle();
    @(negedge clk) in_tvalid = 1'b0;
    while (expected_px.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [clr_pkg::DIM_W-1:0] v);
    int unsigned s;
    @(negedge clk);
    cfg_wr_en = 1'b1; cfg_index = idx; cfg_wdata = v;
    @(negedge clk) cfg_wr_en = 1'b0;
    s = v;
    if (s < 1) s = 1;
    if (s > clr_pkg::MAX_FRAME_DIM) s = clr_pkg::MAX_FRAME_DIM;
    if (idx == clr_pkg::REG_WIDTH) fw = s;
    else if (idx == clr_pkg::REG_HEIGHT) fh = s;
  endtask

  function automatic int near_coord(int unsigned lim);
    return $urandom_range(lim + 40, 0) - 20;
  endfunction

  task automatic random_lines(int n);
    int stop, sx, sy, ex, ey;
    stop = sent + n;
    while (sent < stop) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(99) < 15) begin
          sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
        end else begin
          sx = near_coord(fw); sy = near_coord(fh);
          ex = sx + $urandom_range(80) - 40; ey = sy + $urandom_range(80) - 40;
        end
        send_request(clr_pkg::OP_LOAD, pack_load(sx, sy, ex, ey, $urandom));
        while (ln_active && sent < stop) begin
          // occasionally abandon the line with a fresh load
          if ($urandom_range(99) < 2) break;
          send_request(clr_pkg::OP_STEP, {$urandom, $urandom, $urandom});
        end
        if ($urandom_range(9) == 0)
          send_request(clr_pkg::OP_STEP, {$urandom, $urandom, $urandom});
      end else
        send_request(clr_pkg::op_t'($urandom_range(1)), {$urandom, $urandom, $urandom});
    end
  endtask

  // receiver side
  initial begin
    forever begin
      @(negedge clk);
      out_tready = calm ? 1'b1 : ($urandom_range(99) < 70 ? 1'b1 : 1'b0);
      if (!calm && $urandom_range(99) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(60, 10)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_px.size() == 0) begin
        $display("%0t: unexpected result status %0d data %h", $time, out_tuser, out_tdata);
        errors++;
      end else begin
        e = expected_px.pop_front();
        if (out_tuser != e.st || out_tlast != e.last || out_tdata[12:0] != e.x ||
            out_tdata[25:13] != e.y || out_tdata[49:26] != e.addr ||
            out_tdata[81:50] != e.col || out_tdata[82] != e.we ||
            out_tdata[87:83] != 5'd0) begin
          $display("%0t: mismatch exp st=%0d x=%0d y=%0d a=%0d c=%h we=%0b last=%0b",
                   $time, e.st, e.x, e.y, e.addr, e.col, e.we, e.last);
          $display("%0t:          got st=%0d x=%0d y=%0d a=%0d c=%h we=%0b last=%0b",
                   $time, out_tuser, out_tdata[12:0], out_tdata[25:13],
                   out_tdata[49:26], out_tdata[81:50], out_tdata[82], out_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no request or result moving
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  row_t plan[] = '{
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 1, clr_pkg::ST_NO_LINE},
    '{clr_pkg::OP_LOAD, -10, 5, -1, 400, 32'h1, 1, clr_pkg::ST_REJECTED},
    '{clr_pkg::OP_LOAD, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, clr_pkg::ST_ACCEPTED},
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 0, clr_pkg::ST_PIXEL},
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 1, clr_pkg::ST_NO_LINE},
    '{clr_pkg::OP_LOAD, 640, 480, 637, 478, 32'hA5A5_5A5A, 1, clr_pkg::ST_ACCEPTED},
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 0, clr_pkg::ST_PIXEL},
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 0, clr_pkg::ST_PIXEL},
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 0, clr_pkg::ST_PIXEL},
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 0, clr_pkg::ST_PIXEL},
    '{clr_pkg::OP_LOAD, -32768, -32768, 32767, 32767, 32'h8000_0001, 0,
      clr_pkg::ST_ACCEPTED},
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 0, clr_pkg::ST_PIXEL},
    '{clr_pkg::OP_LOAD, 100, -50, 120, 600, 32'h0123_4567, 0, clr_pkg::ST_ACCEPTED},
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 0, clr_pkg::ST_PIXEL},
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 0, clr_pkg::ST_PIXEL},
    '{clr_pkg::OP_LOAD, 32767, 0, 32767, 5, 32'h2, 1, clr_pkg::ST_REJECTED},
    '{clr_pkg::OP_LOAD, 5, -32768, 6, -1, 32'h3, 1, clr_pkg::ST_REJECTED},
    '{clr_pkg::OP_LOAD, 32767, 32767, -32768, -32768, 32'h4, 0, clr_pkg::ST_ACCEPTED},
    '{clr_pkg::OP_LOAD, -5, 700, 650, -9, 32'h5, 0, clr_pkg::ST_ACCEPTED},
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 0, clr_pkg::ST_PIXEL},
    '{clr_pkg::OP_LOAD, 10, 10, 5, 20, 32'h6, 1, clr_pkg::ST_ACCEPTED},
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 0, clr_pkg::ST_PIXEL},
    '{clr_pkg::OP_STEP, 0, 0, 0, 0, 32'h0, 0, clr_pkg::ST_PIXEL}
  };

  initial begin
    int each;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    foreach (plan[i])
      send_request(plan[i].op, pack_load(plan[i].sx, plan[i].sy, plan[i].ex, plan[i].ey,
                   plan[i].col), plan[i].typed, plan[i].st);
    each = RAND_ITEMS / 6;
    random_lines(each);
    // sender holds off until the block has drained
    wait_idle();
    calm = 1'b1;
    random_lines(40);
    calm = 1'b0;
    wait_idle();
    write_reg(clr_pkg::REG_WIDTH, 13'd1);
    write_reg(clr_pkg::REG_HEIGHT, 13'd1);
    random_lines(each);
    wait_idle();
    write_reg(clr_pkg::REG_WIDTH, 13'd4096);
    write_reg(clr_pkg::REG_HEIGHT, 13'd4096);
    random_lines(each);
    wait_idle();
    write_reg(clr_pkg::REG_WIDTH, 13'd0);
    write_reg(clr_pkg::REG_HEIGHT, 13'h1FFF);
    random_lines(each);
    wait_idle();
    write_reg(clr_pkg::REG_WIDTH, clr_pkg::DIM_W'($urandom_range(200, 2)));
    write_reg(clr_pkg::REG_HEIGHT, clr_pkg::DIM_W'($urandom_range(200, 2)));
    write_reg(REG_SPARE_A, clr_pkg::DIM_W'($urandom));
    write_reg(REG_SPARE_B, clr_pkg::DIM_W'($urandom));
    random_lines(each);
    wait_idle();
    write_reg(clr_pkg::REG_WIDTH, clr_pkg::DIM_W'($urandom));
    write_reg(clr_pkg::REG_HEIGHT, clr_pkg::DIM_W'($urandom));
    random_lines(each);
    @(negedge clk) in_tvalid = 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
